>>> rtl/assert_macros.svh
// Assertion macros shared by the Playfair encryption RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define PLF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PLF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/plf_pkg.sv
// Shared types and constants of the Playfair digraph encryption block.
package plf_pkg;

	localparam int LETTER_W = 5;
	localparam int SIDE = 5;
	localparam int POS_W = 3;
	localparam int CFG_INDEX_W = 2;
	localparam int ROWS_PAIR_W = 2 * SIDE * LETTER_W;
	localparam int ROW_W = SIDE * LETTER_W;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [LETTER_W-1:0] letter_t;

	localparam letter_t LETTER_I = letter_t'(8);
	localparam letter_t LETTER_J = letter_t'(9);
	localparam letter_t LETTER_X = letter_t'(23);
	localparam letter_t LETTER_Z = letter_t'(25);

	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_01 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_23 = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_4 = 2'd2;

	// Key square indexed [row][col].
	typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] square_t;

	typedef struct packed {
		letter_t first;
		letter_t second;
		logic last;
	} pair_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

endpackage

>>> rtl/plf_front.sv
// Front end: takes plaintext letters, forms digraphs and queues them.
`include "assert_macros.svh"

module plf_front (
	input  logic clk,
	input  logic arst_n,
	input  logic plain_valid,
	input  plf_pkg::letter_t plain_letter,
	input  logic end_of_text,
	output logic plain_stall,
	input  logic q_full,
	output logic push,
	output plf_pkg::pair_t push_pair
);
	import plf_pkg::*;

	letter_t held_letter_q;
	logic held_valid_q;
	letter_t pend_letter_q;
	logic pend_q;
	letter_t norm;
	logic accept;

	function automatic letter_t normalize(input letter_t v);
		letter_t l;
		l = v;
		if (l > LETTER_Z) l = LETTER_Z;
		if (l == LETTER_J) l = LETTER_I;
		return l;
	endfunction

	assign norm = normalize(plain_letter);
	assign plain_stall = pend_q || q_full;
	assign accept = plain_valid && !plain_stall;

	always_comb begin
		push = 1'b0;
		push_pair = '{first: norm, second: LETTER_X, last: 1'b1};
		if (pend_q) begin
			push = !q_full;
			push_pair = '{first: pend_letter_q, second: LETTER_X, last: 1'b1};
		end else if (accept) begin
			if (!held_valid_q) begin
				push = end_of_text;
			end else if (held_letter_q != norm) begin
				push = 1'b1;
				push_pair = '{first: held_letter_q, second: norm, last: 1'b1};
			end else begin
				// doubled letter: pad with x, a second pair follows at end of text
				push = 1'b1;
				push_pair = '{first: held_letter_q, second: LETTER_X, last: !end_of_text};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q <= 1'b0;
			pend_letter_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && !q_full) pend_q <= 1'b0;
			if (accept) begin
				if (!held_valid_q) begin
					held_letter_q <= norm;
					held_valid_q <= !end_of_text;
				end else if (held_letter_q != norm) begin
					held_valid_q <= 1'b0;
				end else if (end_of_text) begin
					held_valid_q <= 1'b0;
					pend_q <= 1'b1;
					pend_letter_q <= norm;
				end
			end
		end
	end

	`PLF_ASSERT_ALWAYS(a_pend_not_held, pend_q |-> !held_valid_q, "pending pad while letter held")
	`PLF_ASSERT(a_pend_drains, (pend_q && !q_full) |=> !pend_q, "pending pair not drained")

endmodule

>>> rtl/plf_queue.sv
// Short queue of digraphs between front and back end.
`include "assert_macros.svh"

module plf_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  plf_pkg::pair_t push_pair,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output plf_pkg::pair_t head_pair
);
	import plf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pair_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_pair = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`PLF_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
	`PLF_ASSERT(a_no_underflow, pop |-> head_valid, "pop from empty queue")

endmodule

>>> rtl/plf_back.sv
// Back end: locates a digraph in the key square and emits two cipher letters.
`include "assert_macros.svh"

module plf_back (
	input  logic clk,
	input  logic arst_n,
	input  plf_pkg::square_t square,
	input  logic head_valid,
	input  plf_pkg::pair_t head_pair,
	output logic pop,
	output logic cipher_valid,
	input  logic cipher_stall,
	output plf_pkg::letter_t cipher_letter,
	output logic last_of_run
);
	import plf_pkg::*;

	typedef struct packed {
		pos_t a;
		pos_t b;
		logic last;
	} located_t;

	pair_t pair_s1;
	logic valid_s1;
	located_t loc_s2;
	logic valid_s2;
	logic phase_q;
	letter_t letter_q;
	logic last_q;
	logic out_valid_q;

	logic out_load, s2_done, s2_load, s1_load;
	pos_t own, other, enc;

	// Lowest-numbered cell wins; a missing letter sits at row 0, column 0.
	function automatic pos_t find_cell(input square_t sq, input letter_t l);
		pos_t p;
		p = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (sq[r][c] == l) p = '{row: POS_W'(r), col: POS_W'(c)};
			end
		end
		return p;
	endfunction

	function automatic logic [POS_W-1:0] wrap_inc(input logic [POS_W-1:0] v);
		return (v == POS_W'(SIDE - 1)) ? '0 : v + 1'b1;
	endfunction

	assign out_load = valid_s2 && (!out_valid_q || !cipher_stall);
	assign s2_done = out_load && phase_q;
	assign s2_load = valid_s1 && (!valid_s2 || s2_done);
	assign s1_load = head_valid && (!valid_s1 || s2_load);
	assign pop = s1_load;

	always_comb begin
		own = phase_q ? loc_s2.b : loc_s2.a;
		other = phase_q ? loc_s2.a : loc_s2.b;
		if (own.row == other.row) begin
			enc = '{row: own.row, col: wrap_inc(own.col)};
		end else if (own.col == other.col) begin
			enc = '{row: wrap_inc(own.row), col: own.col};
		end else begin
			enc = '{row: own.row, col: other.col};
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) pair_s1 <= head_pair;
		if (s2_load) begin
			loc_s2.a <= find_cell(square, pair_s1.first);
			loc_s2.b <= find_cell(square, pair_s1.second);
			loc_s2.last <= pair_s1.last;
		end
		if (out_load) begin
			letter_q <= square[enc.row][enc.col];
			last_q <= loc_s2.last && phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) valid_s1 <= 1'b1;
			else if (s2_load) valid_s1 <= 1'b0;
			if (s2_load) valid_s2 <= 1'b1;
			else if (s2_done) valid_s2 <= 1'b0;
			if (out_load) phase_q <= !phase_q;
			if (out_load) out_valid_q <= 1'b1;
			else if (!cipher_stall) out_valid_q <= 1'b0;
		end
	end

	assign cipher_valid = out_valid_q;
	assign cipher_letter = letter_q;
	assign last_of_run = last_q;

	`PLF_ASSERT(a_phase_has_pair, phase_q |-> valid_s2, "second letter phase without a pair")
	`PLF_ASSERT(a_phase_resets, s2_done |=> !phase_q, "phase not back to first letter")

endmodule

>>> rtl/playfair_digraph_encrypt.sv
// Top level of the Playfair digraph encryption block.
// Usage:
//   Load the key square through the cfg channel (index 0: rows 0 and 1,
//   index 1: rows 2 and 3, index 2: row 4, five bits per cell, cell 0
//   lowest). cfg_ready is always high; write only while the block is idle.
//   Send plaintext letters on plain_valid/plain_letter/end_of_text; a request
//   is taken when plain_valid is high and plain_stall is low.
//   Cipher letters leave on cipher_valid/cipher_letter/last_of_run and are
//   taken when cipher_valid is high and cipher_stall is low.
// Path: the first cipher letter of a digraph passes the digraph queue and
//   the pair, location and output registers once the letter completing it
//   is taken; the second follows it. A held first letter gives no output.
// Throughput: one cipher letter per cycle while cipher_stall is low, set by
//   the single output register. A digraph gives two cipher letters, so
//   distinct letter pairs sustain one plaintext letter per cycle. A doubled
//   letter or a lone letter at end of text forms a digraph by itself; a
//   doubled letter at end of text gives two digraphs and stalls plain input.
// Reset clears the held letter, the digraph queue, the pipeline and the key
//   square. A stalled output holds its letter; the two-entry digraph queue
//   and the pipeline fill, after which plain_stall rises.
module playfair_digraph_encrypt (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [plf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [plf_pkg::ROWS_PAIR_W-1:0] cfg_data,
	input  logic plain_valid,
	output logic plain_stall,
	input  plf_pkg::letter_t plain_letter,
	input  logic end_of_text,
	output logic cipher_valid,
	input  logic cipher_stall,
	output plf_pkg::letter_t cipher_letter,
	output logic last_of_run
);
	import plf_pkg::*;

	logic [ROWS_PAIR_W-1:0] rows_01_q;
	logic [ROWS_PAIR_W-1:0] rows_23_q;
	logic [ROW_W-1:0] row_4_q;
	logic [SIDE*SIDE*LETTER_W-1:0] flat;
	square_t square;

	logic push, q_full, pop, head_valid;
	pair_t push_pair, head_pair;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_01_q <= '0;
			rows_23_q <= '0;
			row_4_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROWS_01: rows_01_q <= cfg_data;
				CFG_ROWS_23: rows_23_q <= cfg_data;
				CFG_ROW_4: row_4_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	assign flat = {row_4_q, rows_23_q, rows_01_q};

	for (genvar r = 0; r < SIDE; r++) begin : g_row
		for (genvar c = 0; c < SIDE; c++) begin : g_col
			assign square[r][c] = flat[(r * SIDE + c) * LETTER_W +: LETTER_W];
		end
	end

	plf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.plain_valid(plain_valid),
		.plain_letter(plain_letter),
		.end_of_text(end_of_text),
		.plain_stall(plain_stall),
		.q_full(q_full),
		.push(push),
		.push_pair(push_pair)
	);

	plf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_pair(push_pair),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_pair(head_pair)
	);

	plf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.square(square),
		.head_valid(head_valid),
		.head_pair(head_pair),
		.pop(pop),
		.cipher_valid(cipher_valid),
		.cipher_stall(cipher_stall),
		.cipher_letter(cipher_letter),
		.last_of_run(last_of_run)
	);

endmodule
